[hw/rtl/fcpi_pkg.sv]
// ----------------------------------------------------------------------------
// fcpi_pkg
// Shared types, constants and the quarter-wave sine table of the FOC
// current controller.
// ----------------------------------------------------------------------------
package fcpi_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int QLEN            = 1 << (SINE_TABLE_BITS - 2);
	localparam int QI_W            = SINE_TABLE_BITS - 1;

	localparam int DIV_NW = 46;
	localparam int DIV_DW = 31;
	localparam int DIV_CW = 6;
	localparam int SQ_W   = 62;

	localparam logic [1:0] CFG_KP  = 2'd0;
	localparam logic [1:0] CFG_KI  = 2'd1;
	localparam logic [1:0] CFG_LIM = 2'd2;

	localparam logic [14:0] LIM_RESET = 15'd25540;

	typedef logic [14:0] sine_qtr_t [QLEN + 1];

	typedef enum logic [5:0] {
		OP_NONE, OP_LOAD, OP_SIN, OP_COS, OP_IB, OP_ID1, OP_ID2, OP_IQ1, OP_IQ2,
		OP_PD, OP_PQ, OP_VQ, OP_INCD, OP_INCQ,
		OP_DVD_GO, OP_DVD_PUT, OP_DVQ_GO, OP_DVQ_PUT,
		OP_ABS, OP_NORM, OP_SQ1, OP_SQ2, OP_SQ3, OP_CMP,
		OP_SQRT_GO, OP_SCD, OP_LD_GO, OP_LD_PUT, OP_SCQ, OP_LQ_GO, OP_LQ_PUT,
		OP_INTEG, OP_A1, OP_A2, OP_A3, OP_B1, OP_B2, OP_OUT
	} op_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_SIN, ST_COS, ST_IB, ST_ID1, ST_ID2, ST_IQ1, ST_IQ2,
		ST_PD, ST_PQ, ST_VQ, ST_INCD, ST_INCQ,
		ST_DVD_GO, ST_DVD_W, ST_DVD_PUT, ST_DVQ_GO, ST_DVQ_W, ST_DVQ_PUT,
		ST_ABS, ST_NORM, ST_SQ1, ST_SQ2, ST_SQ3, ST_CMP, ST_CHK,
		ST_SQRT_GO, ST_SQRT_W, ST_SCD, ST_LD_GO, ST_LD_W, ST_LD_PUT,
		ST_SCQ, ST_LQ_GO, ST_LQ_W, ST_LQ_PUT,
		ST_INTEG, ST_A1, ST_A2, ST_A3, ST_B1, ST_B2, ST_FIN
	} state_t;

	typedef struct packed {
		op_t  op;
		logic in_ready;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic div_done;
		logic sqrt_done;
		logic norm_done;
		logic limited;
	} stat_t;

	typedef struct packed {
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
		logic signed [15:0] id;
		logic signed [15:0] iq;
		logic               limited;
	} result_t;

	function automatic sine_qtr_t build_sine_qtr();
		sine_qtr_t t;
		longint x, x2, p, y;
		for (int r = 0; r <= QLEN; r++) begin
			x  = longint'(r) <<< (32 - SINE_TABLE_BITS);
			x2 = (x * x) >>> 30;
			p  = 64'sd80710782;
			p  = -64'sd693598671 + ((p * x2) >>> 30);
			p  = 64'sd1686629713 + ((p * x2) >>> 30);
			y  = (p * x) >>> 30;
			y  = (y + 64'sd16384) >>> 15;
			if (y > 64'sd32767) y = 64'sd32767;
			if (y < 64'sd0) y = 64'sd0;
			t[r] = y[14:0];
		end
		return t;
	endfunction

	localparam sine_qtr_t SINE_QTR = build_sine_qtr();

endpackage

[hw/rtl/fcpi_div.sv]
// ----------------------------------------------------------------------------
// fcpi_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcpi_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [fcpi_pkg::DIV_NW-1:0] num,
	input  logic [fcpi_pkg::DIV_DW-1:0] den,
	output logic                      done,
	output logic [fcpi_pkg::DIV_NW-1:0] quo
);
	import fcpi_pkg::*;

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              fit;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign fit   = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CW'(DIV_NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == DIV_CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= fit ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[hw/rtl/fcpi_sqrt.sv]
// ----------------------------------------------------------------------------
// fcpi_sqrt
// Integer square root, floor, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module fcpi_sqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [fcpi_pkg::SQ_W-1:0] radicand,
	output logic                    done,
	output logic [fcpi_pkg::DIV_DW-1:0] root
);
	import fcpi_pkg::*;

	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic            done_q;
	logic [SQ_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			bit_q  <= SQ_W'(1) << (SQ_W - 2);
			done_q <= 1'b0;
		end else if (bit_q != '0) begin
			bit_q  <= bit_q >> 2;
			done_q <= (bit_q == SQ_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
		end else if (bit_q != '0) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign root = res_q[DIV_DW-1:0];

endmodule

[hw/rtl/fcpi_datapath.sv]
// ----------------------------------------------------------------------------
// fcpi_datapath
// Registers, sine table, shared multiplier, divider and square root of the
// current loop, driven by the controller with at most one operation per cycle.
// ----------------------------------------------------------------------------
module fcpi_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fcpi_pkg::cmd_t       cmd,
	input  logic [95:0]          in_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_wdata,
	output logic                 div_done,
	output logic                 sqrt_done,
	output logic                 norm_done,
	output logic                 limited,
	output fcpi_pkg::result_t    res
);
	import fcpi_pkg::*;

	logic [23:0] kp_q, ki_q;
	logic [14:0] lim_q;

	logic signed [15:0] pb_q, pc_q, td_q, tq_q;
	logic [SINE_TABLE_BITS-1:0] k_q;
	logic [15:0] vbus_q;
	logic signed [15:0] s_q, c_q;
	logic signed [17:0] ia_q, dbc_q, ib_q;
	logic signed [15:0] id_q, iq_q;
	logic signed [16:0] ed_q, eq_q;
	logic signed [33:0] vd_q, vq_q, incd_q, incq_q;
	logic signed [31:0] integ_d_q, integ_q_q;
	logic signed [43:0] md_q, mq_q;
	logic [42:0] ad_q, aq_q;
	logic        sh_q, lim_flag_q, div_neg_q;
	logic [SQ_W-1:0] sum_q;
	logic signed [63:0] acc_q, prod_q;
	logic signed [15:0] alpha_q, beta_q;

	logic [SINE_TABLE_BITS-1:0] rk;
	logic [1:0]       quad;
	logic [QI_W-1:0]  r0, ri;
	logic signed [15:0] rom_val;
	logic signed [31:0] ma, mb;
	logic signed [63:0] mp;
	logic signed [63:0] dn, dmag;
	logic [DIV_DW-1:0]  dden;
	logic               div_go;
	logic [DIV_NW-1:0]  div_num, quo;
	logic [DIV_DW-1:0]  root;
	logic signed [31:0] sd, sq;
	logic signed [63:0] qs;

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) return 16'sh7fff;
		if (v < -64'sd32768) return -16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh7fffffff) return 32'sh7fffffff;
		if (v < -64'sh80000000) return -32'sh80000000;
		return v[31:0];
	endfunction

	// sine table, one read site
	assign rk   = (cmd.op == OP_COS) ? k_q + SINE_TABLE_BITS'(QLEN) : k_q;
	assign quad = rk[SINE_TABLE_BITS-1 -: 2];
	assign r0   = {1'b0, rk[SINE_TABLE_BITS-3:0]};
	assign ri   = quad[0] ? QI_W'(QLEN) - r0 : r0;
	assign rom_val = quad[1] ? -$signed({1'b0, SINE_QTR[ri]}) : $signed({1'b0, SINE_QTR[ri]});

	assign sd = md_q[43] ? -$signed({2'b0, ad_q[29:0]}) : $signed({2'b0, ad_q[29:0]});
	assign sq = mq_q[43] ? -$signed({2'b0, aq_q[29:0]}) : $signed({2'b0, aq_q[29:0]});

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_COS: begin ma = 32'(dbc_q); mb = 32'sd18919; end
			OP_IB:  begin ma = 32'(c_q); mb = 32'(ia_q); end
			OP_ID1: begin ma = 32'(s_q); mb = 32'(ib_q); end
			OP_ID2: begin ma = 32'(c_q); mb = 32'(ib_q); end
			OP_IQ1: begin ma = 32'(s_q); mb = 32'(ia_q); end
			OP_PD:  begin ma = 32'(ed_q); mb = {8'd0, kp_q}; end
			OP_PQ:  begin ma = 32'(eq_q); mb = {8'd0, kp_q}; end
			OP_VQ:  begin ma = 32'(ed_q); mb = {8'd0, ki_q}; end
			OP_INCD: begin ma = 32'(eq_q); mb = {8'd0, ki_q}; end
			OP_SQ1: begin ma = {2'b0, ad_q[29:0]}; mb = {2'b0, ad_q[29:0]}; end
			OP_SQ2: begin ma = {2'b0, aq_q[29:0]}; mb = {2'b0, aq_q[29:0]}; end
			OP_SQ3: begin ma = {17'd0, lim_q}; mb = {17'd0, lim_q}; end
			OP_SCD: begin ma = sd; mb = {17'd0, lim_q}; end
			OP_SCQ: begin ma = sq; mb = {17'd0, lim_q}; end
			OP_A1:  begin ma = 32'(c_q); mb = 32'($signed(md_q[15:0])); end
			OP_A2:  begin ma = 32'(s_q); mb = 32'($signed(mq_q[15:0])); end
			OP_A3:  begin ma = 32'(c_q); mb = 32'($signed(mq_q[15:0])); end
			OP_B1:  begin ma = 32'(s_q); mb = 32'($signed(md_q[15:0])); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign mp = ma * mb;

	always_comb begin
		dn   = prod_q;
		dden = root;
		case (cmd.op)
			OP_DVD_GO: begin
				dn   = (64'(vd_q) <<< 7) + (64'(vd_q) <<< 6);
				dden = (vbus_q == '0) ? DIV_DW'(1) : DIV_DW'(vbus_q);
			end
			OP_DVQ_GO: begin
				dn   = (64'(vq_q) <<< 7) + (64'(vq_q) <<< 6);
				dden = (vbus_q == '0) ? DIV_DW'(1) : DIV_DW'(vbus_q);
			end
			default: begin
				dn   = prod_q;
				dden = root;
			end
		endcase
	end

	assign dmag    = dn[63] ? -dn : dn;
	assign div_num = dmag[DIV_NW-1:0] + DIV_NW'(dden >> 1);
	assign div_go  = (cmd.op == OP_DVD_GO) || (cmd.op == OP_DVQ_GO) ||
	                 (cmd.op == OP_LD_GO) || (cmd.op == OP_LQ_GO);
	assign qs      = div_neg_q ? -$signed({18'd0, quo}) : $signed({18'd0, quo});

	fcpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (div_num),
		.den    (dden),
		.done   (div_done),
		.quo    (quo)
	);

	fcpi_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_SQRT_GO),
		.radicand (sum_q),
		.done     (sqrt_done),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q      <= '0;
			ki_q      <= '0;
			lim_q     <= LIM_RESET;
			integ_d_q <= '0;
			integ_q_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KP:  kp_q  <= cfg_wdata;
					CFG_KI:  ki_q  <= cfg_wdata;
					CFG_LIM: lim_q <= cfg_wdata[14:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_INTEG) begin
				integ_d_q <= sat32(64'(integ_d_q) + 64'(incd_q));
				integ_q_q <= sat32(64'(integ_q_q) + 64'(incq_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mp;
		case (cmd.op)
			OP_LOAD: begin
				pb_q   <= in_data[15:0];
				pc_q   <= in_data[31:16];
				k_q    <= in_data[47 -: SINE_TABLE_BITS];
				vbus_q <= in_data[63:48];
				td_q   <= in_data[79:64];
				tq_q   <= in_data[95:80];
			end
			OP_SIN: begin
				s_q   <= rom_val;
				ia_q  <= -18'(pb_q) - 18'(pc_q);
				dbc_q <= 18'(pb_q) - 18'(pc_q);
			end
			OP_COS: c_q  <= rom_val;
			OP_IB:  ib_q <= 18'(rnd(prod_q, 15));
			OP_ID1: acc_q <= prod_q;
			OP_ID2: id_q <= sat16(rnd(acc_q + prod_q, 15));
			OP_IQ1: acc_q <= prod_q;
			OP_IQ2: begin
				iq_q <= sat16(rnd(acc_q - prod_q, 15));
				ed_q <= 17'(td_q) - 17'(id_q);
			end
			OP_PD:   eq_q   <= 17'(tq_q) - 17'(iq_q);
			OP_PQ:   vd_q   <= 34'(integ_d_q) + 34'(rnd(prod_q, 8));
			OP_VQ:   vq_q   <= 34'(integ_q_q) + 34'(rnd(prod_q, 8));
			OP_INCD: incd_q <= 34'(rnd(prod_q, 8));
			OP_INCQ: incq_q <= 34'(rnd(prod_q, 8));
			OP_DVD_GO, OP_DVQ_GO, OP_LD_GO, OP_LQ_GO: div_neg_q <= dn[63];
			OP_DVD_PUT: md_q <= 44'(qs);
			OP_DVQ_PUT: mq_q <= 44'(qs);
			OP_ABS: begin
				ad_q <= md_q[43] ? 43'(-md_q) : 43'(md_q);
				aq_q <= mq_q[43] ? 43'(-mq_q) : 43'(mq_q);
				sh_q <= 1'b0;
			end
			OP_NORM: begin
				if (!norm_done) begin
					ad_q <= ad_q >> 1;
					aq_q <= aq_q >> 1;
					sh_q <= 1'b1;
				end
			end
			OP_SQ2: acc_q <= prod_q;
			OP_SQ3: sum_q <= SQ_W'(acc_q + prod_q);
			OP_CMP: lim_flag_q <= sh_q || (64'(sum_q) > prod_q);
			OP_LD_PUT: md_q <= 44'(sat16(qs));
			OP_LQ_PUT: mq_q <= 44'(sat16(qs));
			OP_A2: acc_q <= prod_q;
			OP_A3: alpha_q <= sat16(rnd(acc_q - prod_q, 15));
			OP_B1: acc_q <= prod_q;
			OP_B2: beta_q <= sat16(rnd(acc_q + prod_q, 15));
			default: ;
		endcase
	end

	assign norm_done   = (ad_q[42:30] == '0) && (aq_q[42:30] == '0);
	assign limited     = lim_flag_q;
	assign res.alpha   = alpha_q;
	assign res.beta    = beta_q;
	assign res.id      = id_q;
	assign res.iq      = iq_q;
	assign res.limited = lim_flag_q;

endmodule

[hw/rtl/fcpi_ctrl.sv]
// ----------------------------------------------------------------------------
// fcpi_ctrl
// Sequencer of the current loop: walks each request through the datapath.
// ----------------------------------------------------------------------------
module fcpi_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  fcpi_pkg::stat_t st,
	output fcpi_pkg::cmd_t  cmd
);
	import fcpi_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (st.in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_SIN;
				end
			end
			ST_SIN:  begin cmd.op = OP_SIN;  state_d = ST_COS;  end
			ST_COS:  begin cmd.op = OP_COS;  state_d = ST_IB;   end
			ST_IB:   begin cmd.op = OP_IB;   state_d = ST_ID1;  end
			ST_ID1:  begin cmd.op = OP_ID1;  state_d = ST_ID2;  end
			ST_ID2:  begin cmd.op = OP_ID2;  state_d = ST_IQ1;  end
			ST_IQ1:  begin cmd.op = OP_IQ1;  state_d = ST_IQ2;  end
			ST_IQ2:  begin cmd.op = OP_IQ2;  state_d = ST_PD;   end
			ST_PD:   begin cmd.op = OP_PD;   state_d = ST_PQ;   end
			ST_PQ:   begin cmd.op = OP_PQ;   state_d = ST_VQ;   end
			ST_VQ:   begin cmd.op = OP_VQ;   state_d = ST_INCD; end
			ST_INCD: begin cmd.op = OP_INCD; state_d = ST_INCQ; end
			ST_INCQ: begin cmd.op = OP_INCQ; state_d = ST_DVD_GO; end
			ST_DVD_GO: begin cmd.op = OP_DVD_GO; state_d = ST_DVD_W; end
			ST_DVD_W: begin
				if (st.div_done) state_d = ST_DVD_PUT;
			end
			ST_DVD_PUT: begin cmd.op = OP_DVD_PUT; state_d = ST_DVQ_GO; end
			ST_DVQ_GO:  begin cmd.op = OP_DVQ_GO;  state_d = ST_DVQ_W;  end
			ST_DVQ_W: begin
				if (st.div_done) state_d = ST_DVQ_PUT;
			end
			ST_DVQ_PUT: begin cmd.op = OP_DVQ_PUT; state_d = ST_ABS; end
			ST_ABS:  begin cmd.op = OP_ABS; state_d = ST_NORM; end
			ST_NORM: begin
				cmd.op = OP_NORM;
				if (st.norm_done) state_d = ST_SQ1;
			end
			ST_SQ1: begin cmd.op = OP_SQ1; state_d = ST_SQ2; end
			ST_SQ2: begin cmd.op = OP_SQ2; state_d = ST_SQ3; end
			ST_SQ3: begin cmd.op = OP_SQ3; state_d = ST_CMP; end
			ST_CMP: begin cmd.op = OP_CMP; state_d = ST_CHK; end
			ST_CHK: begin
				state_d = st.limited ? ST_SQRT_GO : ST_INTEG;
			end
			ST_SQRT_GO: begin cmd.op = OP_SQRT_GO; state_d = ST_SQRT_W; end
			ST_SQRT_W: begin
				if (st.sqrt_done) state_d = ST_SCD;
			end
			ST_SCD:   begin cmd.op = OP_SCD;   state_d = ST_LD_GO; end
			ST_LD_GO: begin cmd.op = OP_LD_GO; state_d = ST_LD_W;  end
			ST_LD_W: begin
				if (st.div_done) state_d = ST_LD_PUT;
			end
			ST_LD_PUT: begin cmd.op = OP_LD_PUT; state_d = ST_SCQ;   end
			ST_SCQ:    begin cmd.op = OP_SCQ;    state_d = ST_LQ_GO; end
			ST_LQ_GO:  begin cmd.op = OP_LQ_GO;  state_d = ST_LQ_W;  end
			ST_LQ_W: begin
				if (st.div_done) state_d = ST_LQ_PUT;
			end
			ST_LQ_PUT: begin cmd.op = OP_LQ_PUT; state_d = ST_A1; end
			ST_INTEG:  begin cmd.op = OP_INTEG;  state_d = ST_A1; end
			ST_A1: begin cmd.op = OP_A1; state_d = ST_A2; end
			ST_A2: begin cmd.op = OP_A2; state_d = ST_A3; end
			ST_A3: begin cmd.op = OP_A3; state_d = ST_B1; end
			ST_B1: begin cmd.op = OP_B1; state_d = ST_B2; end
			ST_B2: begin cmd.op = OP_B2; state_d = ST_FIN; end
			ST_FIN: begin
				if (st.out_free) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[hw/rtl/foc_current_pi_controller.sv]
// ----------------------------------------------------------------------------
// foc_current_pi_controller
// Field-oriented current loop: Clarke/Park transform, d/q PI control,
// bus-voltage scaling, modulation limit and inverse Park.
// ----------------------------------------------------------------------------
// One current sample is taken at a time. A sample within the modulation
// limit goes on to inverse Park after the two bus-voltage divisions; a sample
// that gets scaled down also passes the square root and two more divisions,
// and a very long vector is normalized first. The work is done by the
// bit-serial divider (two or four quotients per sample), the square root
// and a single shared 32x32 multiplier. The next sample is accepted while a
// finished result still waits on the output.
module foc_current_pi_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// phase_b_current, phase_c_current, rotor_angle, bus_voltage,
	// target_d_current, target_q_current
	input  logic [95:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// alpha_modulation, beta_modulation, measured_d_current, measured_q_current
	output logic [63:0] m_axis_tdata,
	// limited
	output logic        m_axis_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wdata
);
	import fcpi_pkg::*;

	cmd_t    cmd;
	stat_t   st;
	result_t res;
	logic    out_valid_q;
	logic [63:0] out_data_q;
	logic    out_user_q;
	logic    div_done, sqrt_done, norm_done, limited;

	assign st.in_valid  = s_axis_tvalid;
	assign st.out_free  = !out_valid_q || m_axis_tready;
	assign st.div_done  = div_done;
	assign st.sqrt_done = sqrt_done;
	assign st.norm_done = norm_done;
	assign st.limited   = limited;

	fcpi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	fcpi_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.div_done  (div_done),
		.sqrt_done (sqrt_done),
		.norm_done (norm_done),
		.limited   (limited),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			out_data_q <= {res.iq, res.id, res.beta, res.alpha};
			out_user_q <= res.limited;
		end
	end

	assign s_axis_tready = cmd.in_ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule
